### rtl/mhgs_pkg.sv
// ----------------------------------------------------------------------------
// mhgs_pkg: shared types and constants for the hysteresis gate selector
// Holds field widths, channel count, margin, op and register codes, FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package mhgs_pkg;

   // Channel slots are fixed by the 2-bit channel index; CHANNEL_COUNT of them
   // are in use (2..4).
   localparam int SLOT_COUNT    = 4;
   localparam int CHANNEL_COUNT = 4;
   localparam int CHAN_W        = 2;
   localparam int CHAN_CNT_W    = 3;
   localparam int LEVEL_W       = 16;
   localparam int STAMP_W       = 32;
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 16;

   localparam logic [LEVEL_W-1:0] CLOSE_MARGIN      = 16'd655;
   localparam logic [LEVEL_W-1:0] ATTACK_RESET_VAL  = 16'd1311;
   localparam logic [LEVEL_W-1:0] RELEASE_RESET_VAL = 16'd655;

   // Request kinds
   localparam logic OP_LEVEL = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Register groups, selected by the upper bits of the register index
   localparam logic [CSR_INDEX_W-3:0] CSR_GRP_ATTACK  = 2'd0;
   localparam logic [CSR_INDEX_W-3:0] CSR_GRP_RELEASE = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
   } sel_ctrl_type;

   typedef struct packed {
      logic              found;
      logic [CHAN_W-1:0] index;
   } sel_result_type;

endpackage : mhgs_pkg

`default_nettype wire

### rtl/mhgs_select.sv
// ----------------------------------------------------------------------------
// mhgs_select: shared compare unit for the dominant channel scan
// Compares one candidate channel per step against the running best.
// ----------------------------------------------------------------------------
`default_nettype none

module mhgs_select (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire  mhgs_pkg::sel_ctrl_type          ctrl,
   input  wire                                   cand_active,
   input  wire  [mhgs_pkg::CHAN_W-1:0]           cand_index,
   input  wire  [mhgs_pkg::LEVEL_W-1:0]          cand_level,
   input  wire  [mhgs_pkg::STAMP_W-1:0]          cand_stamp,
   output mhgs_pkg::sel_result_type              result_next,
   output mhgs_pkg::sel_result_type              result
);

   logic                           found_ff, found_in;
   logic [mhgs_pkg::CHAN_W-1:0]    best_idx_ff, best_idx_in;
   logic [mhgs_pkg::LEVEL_W-1:0]   best_level_ff, best_level_in;
   logic [mhgs_pkg::STAMP_W-1:0]   best_stamp_ff, best_stamp_in;

   logic [mhgs_pkg::LEVEL_W:0]     best_plus_margin;
   logic [mhgs_pkg::LEVEL_W-1:0]   diff;
   logic                           take;

   always_comb begin
      best_plus_margin = {1'b0, best_level_ff} + {1'b0, mhgs_pkg::CLOSE_MARGIN};
      diff = (cand_level >= best_level_ff) ? (cand_level - best_level_ff)
                                           : (best_level_ff - cand_level);
      take = cand_active &&
             (!found_ff ||
              ({1'b0, cand_level} > best_plus_margin) ||
              ((diff <= mhgs_pkg::CLOSE_MARGIN) && (cand_stamp > best_stamp_ff)));
   end

   always_comb begin
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_level_in = best_level_ff;
      best_stamp_in = best_stamp_ff;
      if (ctrl.start) begin
         found_in      = 1'b0;
         best_idx_in   = '0;
         best_level_in = '0;
         best_stamp_in = '0;
      end else if (ctrl.step && take) begin
         found_in      = 1'b1;
         best_idx_in   = cand_index;
         best_level_in = cand_level;
         best_stamp_in = cand_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         best_idx_ff <= '0;
      end else begin
         found_ff    <= found_in;
         best_idx_ff <= best_idx_in;
      end
      best_level_ff <= best_level_in;
      best_stamp_ff <= best_stamp_in;
   end

   // Value as it stands after a step taken this cycle
   assign result_next.found = (ctrl.step && take) ? 1'b1 : found_ff;
   assign result_next.index = (ctrl.step && take) ? cand_index : best_idx_ff;
   assign result.found      = found_ff;
   assign result.index      = best_idx_ff;

endmodule : mhgs_select

`default_nettype wire

### rtl/multichannel_hysteresis_gate_select.sv
// ----------------------------------------------------------------------------
// multichannel_hysteresis_gate_select: four-channel hysteresis gate
// Per-channel attack/release gating, time stamps on activation, and an
// ordered scan that picks the dominant active channel for every request.
// ----------------------------------------------------------------------------
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+----------------------
//  req     | req_op, req_channel_index,             | req_valid / req_stall
//          | req_envelope_level                     |
//  rsp     | rsp_channel_now_active, rsp_pluck_event| rsp_valid / rsp_stall
//          | rsp_dominant_*, rsp_last_*             |
//  csr     | csr_index, csr_write_data              | csr_write_enable
//
//  A request first updates the gate or the time counter, then steps through
//  each channel in order in the shared compare unit of the dominant scan.
//  req_stall is high while a request is in flight; the result then waits in
//  the rsp register, and the next request is taken once it has been loaded.
//  A stalled rsp holds the scan result in the EMIT state until the output
//  register frees up. Synchronous reset clears gates and counters and reloads
//  the default thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_hysteresis_gate_select (
   input  wire                                  clock,
   input  wire                                  reset,

   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire                                  req_op,
   input  wire  [mhgs_pkg::CHAN_W-1:0]          req_channel_index,
   input  wire  [mhgs_pkg::LEVEL_W-1:0]         req_envelope_level,

   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_channel_now_active,
   output logic                                 rsp_pluck_event,
   output logic                                 rsp_dominant_valid,
   output logic [mhgs_pkg::CHAN_W-1:0]          rsp_dominant_channel,
   output logic                                 rsp_last_valid,
   output logic [mhgs_pkg::CHAN_W-1:0]          rsp_last_channel,

   input  wire                                  csr_write_enable,
   input  wire  [mhgs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [mhgs_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam logic [mhgs_pkg::CHAN_W-1:0] LAST_SCAN_IDX =
      mhgs_pkg::CHAN_W'(mhgs_pkg::CHANNEL_COUNT - 1);

   // ---------------------------------------------------------------- state
   mhgs_pkg::state_type               state_ff, state_in;

   logic [mhgs_pkg::LEVEL_W-1:0]      attack_ff  [mhgs_pkg::SLOT_COUNT];
   logic [mhgs_pkg::LEVEL_W-1:0]      release_ff [mhgs_pkg::SLOT_COUNT];

   logic [mhgs_pkg::SLOT_COUNT-1:0]   gate_ff, gate_in;
   logic [mhgs_pkg::LEVEL_W-1:0]      level_ff   [mhgs_pkg::SLOT_COUNT];
   logic [mhgs_pkg::STAMP_W-1:0]      stamp_ff   [mhgs_pkg::SLOT_COUNT];
   logic [mhgs_pkg::STAMP_W-1:0]      time_ff, time_in;
   logic [mhgs_pkg::CHAN_W-1:0]       last_ch_ff, last_ch_in;
   logic                              last_valid_ff, last_valid_in;

   logic                              now_active_ff, now_active_in;
   logic                              pluck_ff, pluck_in;
   logic [mhgs_pkg::CHAN_W-1:0]       scan_idx_ff, scan_idx_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_active_ff, rsp_pluck_ff;
   logic                              rsp_dom_valid_ff;
   logic [mhgs_pkg::CHAN_W-1:0]       rsp_dom_ch_ff;
   logic                              rsp_last_valid_ff;
   logic [mhgs_pkg::CHAN_W-1:0]       rsp_last_ch_ff;

   // ---------------------------------------------------------------- control
   logic                              accept;
   logic                              level_write;
   logic                              scan_last;
   logic                              out_free;
   logic                              rsp_load;
   logic                              load_from_next;
   mhgs_pkg::sel_ctrl_type            sel_ctrl;
   mhgs_pkg::sel_result_type          sel_next, sel_result, sel_pick;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_last = (scan_idx_ff == LAST_SCAN_IDX);

   // Level requests to a slot beyond the channel count are dropped.
   assign level_write = accept && (req_op == mhgs_pkg::OP_LEVEL) &&
      ({1'b0, req_channel_index} < mhgs_pkg::CHAN_CNT_W'(mhgs_pkg::CHANNEL_COUNT));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mhgs_pkg::ST_IDLE: begin
            if (accept) state_in = mhgs_pkg::ST_SCAN;
         end
         mhgs_pkg::ST_SCAN: begin
            if (scan_last) state_in = out_free ? mhgs_pkg::ST_IDLE : mhgs_pkg::ST_EMIT;
         end
         mhgs_pkg::ST_EMIT: begin
            if (out_free) state_in = mhgs_pkg::ST_IDLE;
         end
         default: state_in = mhgs_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall      = 1'b1;
      sel_ctrl.start = 1'b0;
      sel_ctrl.step  = 1'b0;
      rsp_load       = 1'b0;
      load_from_next = 1'b0;
      case (state_ff)
         mhgs_pkg::ST_IDLE: begin
            req_stall      = 1'b0;
            sel_ctrl.start = req_valid;
         end
         mhgs_pkg::ST_SCAN: begin
            sel_ctrl.step  = 1'b1;
            rsp_load       = scan_last && out_free;
            load_from_next = 1'b1;
         end
         mhgs_pkg::ST_EMIT: begin
            rsp_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ---------------------------------------------------------------- gate update
   // Apply the gate with hysteresis at the accept edge; tick advances time.
   always_comb begin
      gate_in       = gate_ff;
      time_in       = time_ff;
      last_ch_in    = last_ch_ff;
      last_valid_in = last_valid_ff;
      now_active_in = now_active_ff;
      pluck_in      = pluck_ff;
      if (accept) begin
         now_active_in = 1'b0;
         pluck_in      = 1'b0;
         if (req_op == mhgs_pkg::OP_TICK) begin
            time_in = time_ff + mhgs_pkg::STAMP_W'(1);
         end else if (level_write) begin
            if (!gate_ff[req_channel_index]) begin
               if (req_envelope_level > attack_ff[req_channel_index]) begin
                  gate_in[req_channel_index] = 1'b1;
                  last_ch_in    = req_channel_index;
                  last_valid_in = 1'b1;
                  pluck_in      = 1'b1;
               end
            end else if (req_envelope_level < release_ff[req_channel_index]) begin
               gate_in[req_channel_index] = 1'b0;
            end
            now_active_in = gate_in[req_channel_index];
         end
      end
   end

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (accept) begin
         scan_idx_in = '0;
      end else if (sel_ctrl.step && !scan_last) begin
         scan_idx_in = scan_idx_ff + mhgs_pkg::CHAN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mhgs_pkg::ST_IDLE;
         gate_ff       <= '0;
         time_ff       <= '0;
         last_ch_ff    <= '0;
         last_valid_ff <= 1'b0;
         now_active_ff <= 1'b0;
         pluck_ff      <= 1'b0;
         scan_idx_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         gate_ff       <= gate_in;
         time_ff       <= time_in;
         last_ch_ff    <= last_ch_in;
         last_valid_ff <= last_valid_in;
         now_active_ff <= now_active_in;
         pluck_ff      <= pluck_in;
         scan_idx_ff   <= scan_idx_in;
      end
   end

   // Held level and activation stamp are only read for active channels,
   // which have always been written first.
   always_ff @(posedge clock) begin
      if (level_write) begin
         level_ff[req_channel_index] <= req_envelope_level;
         if (!gate_ff[req_channel_index] &&
             (req_envelope_level > attack_ff[req_channel_index])) begin
            stamp_ff[req_channel_index] <= time_ff;
         end
      end
   end

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mhgs_pkg::SLOT_COUNT; i++) begin
            attack_ff[i]  <= mhgs_pkg::ATTACK_RESET_VAL;
            release_ff[i] <= mhgs_pkg::RELEASE_RESET_VAL;
         end
      end else if (csr_write_enable) begin
         case (csr_index[mhgs_pkg::CSR_INDEX_W-1:2])
            mhgs_pkg::CSR_GRP_ATTACK:  attack_ff[csr_index[1:0]]  <= csr_write_data;
            mhgs_pkg::CSR_GRP_RELEASE: release_ff[csr_index[1:0]] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- scan
   mhgs_select u_select (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (sel_ctrl),
      .cand_active (gate_ff[scan_idx_ff]),
      .cand_index  (scan_idx_ff),
      .cand_level  (level_ff[scan_idx_ff]),
      .cand_stamp  (stamp_ff[scan_idx_ff]),
      .result_next (sel_next),
      .result      (sel_result)
   );

   // On the last scan step take the result as it forms; later take it held.
   assign sel_pick = load_from_next ? sel_next : sel_result;

   // ---------------------------------------------------------------- output
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_active_ff     <= now_active_ff;
         rsp_pluck_ff      <= pluck_ff;
         rsp_dom_valid_ff  <= sel_pick.found;
         rsp_dom_ch_ff     <= sel_pick.index;
         rsp_last_valid_ff <= last_valid_ff;
         rsp_last_ch_ff    <= last_ch_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_channel_now_active = rsp_active_ff;
   assign rsp_pluck_event        = rsp_pluck_ff;
   assign rsp_dominant_valid     = rsp_dom_valid_ff;
   assign rsp_dominant_channel   = rsp_dom_ch_ff;
   assign rsp_last_valid         = rsp_last_valid_ff;
   assign rsp_last_channel       = rsp_last_ch_ff;

   // ---------------------------------------------------------------- checks
   // A taken request always restarts the scan at channel zero.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == mhgs_pkg::ST_SCAN) && (scan_idx_ff == '0))
      else $error("scan did not restart after a request");

   // A pluck means the channel is now active and has been recorded as last.
   a_pluck_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pluck_ff) |-> (rsp_active_ff && rsp_last_valid_ff))
      else $error("pluck without active gate or last channel");

   // Any active channel implies some activation has happened.
   a_dominant_implies_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dom_valid_ff) |-> rsp_last_valid_ff)
      else $error("dominant channel without any activation");

   // The result register is loaded only from the scan path.
   a_load_state: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (state_ff != mhgs_pkg::ST_IDLE))
      else $error("result loaded while idle");

endmodule : multichannel_hysteresis_gate_select

`default_nettype wire
